// ===== design/btq_pkg.sv =====
// ---------------------------------------------------------------------------
// btq_pkg
// Shared types, codes and pixel classification for the tricolor quantizer.
// ---------------------------------------------------------------------------
package btq_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int MAX_ROW_WIDTH   = 4096;
	localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int WIDTH_LIM       = (MAX_ROW_WIDTH < 4096) ? MAX_ROW_WIDTH : 4096;
	localparam int QDEPTH          = 4;
	localparam int QAW             = $clog2(QDEPTH);

	// pixel depth codes
	localparam logic [2:0] DEPTH_1  = 3'd0;
	localparam logic [2:0] DEPTH_4  = 3'd1;
	localparam logic [2:0] DEPTH_8  = 3'd2;
	localparam logic [2:0] DEPTH_16 = 3'd3;
	localparam logic [2:0] DEPTH_24 = 3'd4;

	// item operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// result colors
	localparam logic [1:0] COLOR_WHITE = 2'd0;
	localparam logic [1:0] COLOR_RED   = 2'd1;
	localparam logic [1:0] COLOR_BLACK = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DEPTH = 2'd0;
	localparam logic [1:0] CFG_565   = 2'd1;
	localparam logic [1:0] CFG_COLOR = 2'd2;
	localparam logic [1:0] CFG_WIDTH = 2'd3;

	typedef struct packed {
		logic       op;
		logic [7:0] pal_index;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
	} item_t;

	typedef struct packed {
		logic [1:0]  pixel_color;
		logic [11:0] column;
		logic        row_end;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]  depth_code;
		logic        use_565;
		logic        red_en;
		logic [12:0] row_width;
	} cfg_t;

	// one classified pixel between front and back
	typedef struct packed {
		logic white;
		logic colored;
		logic byte_last;
	} pix_t;

	typedef struct packed {
		logic          empty;
		logic [QAW:0]  count;
	} q_stat_t;

	function automatic logic color_on(input cfg_t c);
		return c.red_en && (c.depth_code != DEPTH_1);
	endfunction

	function automatic logic is_whitish(input logic [7:0] r, input logic [7:0] g,
	                                    input logic [7:0] b, input logic col);
		logic [9:0] sum;
		sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
		if (col)
			return (r > 8'h80) && (g > 8'h80) && (b > 8'h80);
		return sum > 10'd384;
	endfunction

	function automatic logic is_colored(input logic [7:0] r, input logic [7:0] g,
	                                    input logic [7:0] b);
		return (r > 8'hF0) || ((g > 8'hF0) && (b > 8'hF0));
	endfunction

endpackage

// ===== design/btq_front.sv =====
// ---------------------------------------------------------------------------
// btq_front
// Accepts items, keeps the palette, splits packed bytes and classifies pixels.
// ---------------------------------------------------------------------------
module btq_front (
	input  logic             clk,
	input  logic             arst_n,
	input  btq_pkg::cfg_t    cfg,
	input  logic             push,
	output logic             full,
	input  btq_pkg::item_t   item,
	input  btq_pkg::q_stat_t qstat,
	output logic             q_push,
	output btq_pkg::pix_t    q_entry
);
	import btq_pkg::*;

	logic        s0_valid_q;
	item_t       s0_item_q;
	logic [2:0]  sub_q;

	logic        s1_valid_s1;
	logic        from_mem_s1;
	logic        inrange_s1;
	logic        w_dir_s1;
	logic        c_dir_s1;
	logic        byte_last_s1;
	logic [1:0]  rd_q;

	logic [1:0]  pal_mem [PALETTE_ENTRIES];

	logic        col;
	logic        is_load;
	logic        packed_px;
	logic [2:0]  final_sub;
	logic        step_ok;
	logic        issue;
	logic        final_step;
	logic        done;
	logic [7:0]  rd_idx;
	logic        rd_inrange;
	logic        wr_inrange;
	logic [7:0]  r, g, b;
	logic [QAW+1:0] in_flight;

	assign col       = color_on(cfg);
	assign is_load   = (s0_item_q.op == OP_LOAD);
	assign packed_px = (cfg.depth_code == DEPTH_1) || (cfg.depth_code == DEPTH_4) ||
	                   (cfg.depth_code == DEPTH_8);

	always_comb begin
		case (cfg.depth_code)
			DEPTH_1: final_sub = 3'd7;
			DEPTH_4: final_sub = 3'd1;
			default: final_sub = 3'd0;
		endcase
	end

	// leave room for the read already in flight
	assign in_flight = {1'b0, qstat.count} + {{(QAW+1){1'b0}}, s1_valid_s1};
	assign step_ok   = in_flight < (QAW+2)'(QDEPTH);
	assign issue      = s0_valid_q && (is_load || step_ok);
	assign final_step = is_load || !packed_px || (sub_q == final_sub);
	assign done       = issue && final_step;
	assign full       = s0_valid_q && !done;

	always_comb begin
		case (cfg.depth_code)
			DEPTH_1: rd_idx = {7'd0, s0_item_q.byte0[3'd7 - sub_q]};
			DEPTH_4: rd_idx = sub_q[0] ? {4'd0, s0_item_q.byte0[3:0]}
			                           : {4'd0, s0_item_q.byte0[7:4]};
			default: rd_idx = s0_item_q.byte0;
		endcase
	end

	assign rd_inrange = {1'b0, rd_idx} < 9'(PALETTE_ENTRIES);
	assign wr_inrange = {1'b0, s0_item_q.pal_index} < 9'(PALETTE_ENTRIES);

	// color recovery for direct pixels and palette loads
	always_comb begin
		if (!is_load && (cfg.depth_code == DEPTH_16)) begin
			b = {s0_item_q.byte0[4:0], 3'b000};
			if (!cfg.use_565) begin
				g = {s0_item_q.byte1[1:0], s0_item_q.byte0[7:5], 3'b000};
				r = {s0_item_q.byte1[6:2], 3'b000};
			end else begin
				g = {s0_item_q.byte1[2:0], s0_item_q.byte0[7:5], 2'b00};
				r = s0_item_q.byte1 & 8'hF8;
			end
		end else begin
			b = s0_item_q.byte0;
			g = s0_item_q.byte1;
			r = s0_item_q.byte2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q <= 1'b0;
			sub_q      <= 3'd0;
		end else begin
			if (push && !full) begin
				s0_valid_q <= 1'b1;
				sub_q      <= 3'd0;
			end else if (done) begin
				s0_valid_q <= 1'b0;
			end else if (issue) begin
				sub_q <= sub_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			s0_item_q <= item;
	end

	always_ff @(posedge clk) begin
		if (issue && is_load && wr_inrange)
			pal_mem[s0_item_q.pal_index[PAL_AW-1:0]] <=
				{is_whitish(r, g, b, col), is_colored(r, g, b)};
	end

	always_ff @(posedge clk) begin
		if (issue && !is_load && packed_px)
			rd_q <= pal_mem[rd_idx[PAL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else
			s1_valid_s1 <= issue && !is_load;
	end

	always_ff @(posedge clk) begin
		if (issue && !is_load) begin
			from_mem_s1  <= packed_px;
			inrange_s1   <= rd_inrange;
			w_dir_s1     <= is_whitish(r, g, b, col);
			c_dir_s1     <= is_colored(r, g, b);
			byte_last_s1 <= final_step;
		end
	end

	assign q_push = s1_valid_s1;

	always_comb begin
		q_entry.byte_last = byte_last_s1;
		if (from_mem_s1) begin
			q_entry.white   = inrange_s1 && rd_q[1];
			q_entry.colored = inrange_s1 && rd_q[0];
		end else begin
			q_entry.white   = w_dir_s1;
			q_entry.colored = c_dir_s1;
		end
	end

endmodule

// ===== design/btq_queue.sv =====
// ---------------------------------------------------------------------------
// btq_queue
// Short queue of classified pixels between the front and the back.
// ---------------------------------------------------------------------------
module btq_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  btq_pkg::pix_t     wr_entry,
	input  logic              rd,
	output btq_pkg::pix_t     rd_entry,
	output btq_pkg::q_stat_t  stat
);
	import btq_pkg::*;

	pix_t         slots_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			slots_q[wptr_q] <= wr_entry;
	end

	assign rd_entry   = slots_q[rptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);

endmodule

// ===== design/btq_back.sv =====
// ---------------------------------------------------------------------------
// btq_back
// Column counter, row-end truncation of packed bytes and the result register.
// ---------------------------------------------------------------------------
module btq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  btq_pkg::cfg_t     cfg,
	input  btq_pkg::q_stat_t  qstat,
	input  btq_pkg::pix_t     q_entry,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output btq_pkg::result_t  result
);
	import btq_pkg::*;

	logic        out_valid_q;
	result_t     out_q;
	logic [11:0] col_q;
	logic        drop_q;

	logic [12:0] eff_w;
	logic        slot_free;
	logic        emit;
	logic        row_end;
	logic        col_en;
	logic [1:0]  color;

	always_comb begin
		if (cfg.row_width == 13'd0)
			eff_w = 13'd1;
		else if (cfg.row_width > 13'(WIDTH_LIM))
			eff_w = 13'(WIDTH_LIM);
		else
			eff_w = cfg.row_width;
	end

	assign col_en    = color_on(cfg);
	assign slot_free = !out_valid_q || pop;
	// drop pixels left in a byte once its row has ended
	assign q_pop     = !qstat.empty && (drop_q || slot_free);
	assign emit      = q_pop && !drop_q;
	assign row_end   = ({1'b0, col_q} + 13'd1) >= eff_w;

	always_comb begin
		if (q_entry.white)
			color = COLOR_WHITE;
		else if (q_entry.colored && col_en)
			color = COLOR_RED;
		else
			color = COLOR_BLACK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= 12'd0;
			drop_q      <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (emit) begin
				col_q  <= row_end ? 12'd0 : col_q + 12'd1;
				drop_q <= row_end && !q_entry.byte_last;
			end else if (q_pop && q_entry.byte_last) begin
				drop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pixel_color <= color;
			out_q.column      <= col_q;
			out_q.row_end     <= row_end;
			out_q.last        <= row_end || q_entry.byte_last;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ===== design/bmp_pixel_tricolor_quantizer_core.sv =====
// ---------------------------------------------------------------------------
// bmp_pixel_tricolor_quantizer_core
// Turns bitmap pixel data into white, red or black codes for a tricolor panel.
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  item     | push / full         | item_t: op, pal_index, byte0..byte2
//  result   | empty / pop         | result_t: pixel_color, column, row_end, last
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
//  One item per cycle for palette loads. While the pixel queue has room,
//  16/24-bit and 8-bit pixels go one per cycle, and a packed 4-bit or 1-bit
//  byte holds the input until its pixels are read, one palette read a cycle.
//  Reset clears control state and loads the default configuration; the
//  palette is not cleared. A stalled result holds.
//  full rises when the pixel queue has no room or a packed byte is unfinished.
// ---------------------------------------------------------------------------
module bmp_pixel_tricolor_quantizer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  btq_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output btq_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [12:0]      cfg_data
);
	import btq_pkg::*;

	cfg_t    cfg_q;
	logic    q_push;
	logic    q_pop;
	pix_t    q_wr_entry;
	pix_t    q_rd_entry;
	q_stat_t qstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_code <= DEPTH_24;
			cfg_q.use_565    <= 1'b0;
			cfg_q.red_en     <= 1'b0;
			cfg_q.row_width  <= 13'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEPTH: cfg_q.depth_code <= cfg_data[2:0];
				CFG_565:   cfg_q.use_565    <= cfg_data[0];
				CFG_COLOR: cfg_q.red_en     <= cfg_data[0];
				CFG_WIDTH: cfg_q.row_width  <= cfg_data;
				default:   cfg_q            <= cfg_q;
			endcase
		end
	end

	btq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.item    (item),
		.qstat   (qstat),
		.q_push  (q_push),
		.q_entry (q_wr_entry)
	);

	btq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_entry (q_wr_entry),
		.rd       (q_pop),
		.rd_entry (q_rd_entry),
		.stat     (qstat)
	);

	btq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.qstat   (qstat),
		.q_entry (q_rd_entry),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
